// ===== src/indexed_insert_remove_list_macros.svh =====
// assertion macros shared by the indexed insert/remove list modules
// no dependencies; assertions compile out when ASSERT_OFF is defined
`ifndef INDEXED_INSERT_REMOVE_LIST_MACROS_SVH
`define INDEXED_INSERT_REMOVE_LIST_MACROS_SVH

`ifndef ASSERT_OFF
`define IIRL_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define IIRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IIRL_ASSERT(lbl, cond, msg)
`define IIRL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/iirl_pkg.sv =====
// shared types and codes for the indexed insert/remove list
// no dependencies
package iirl_pkg;

    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_READ,
        ST_SHIFT,
        ST_INS_WR,
        ST_DONE
    } iirl_state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic capture;
        logic shift;
        logic ins_write;
        logic finish;
    } iirl_cmd_t;

    typedef struct packed {
        logic go_read;
        logic go_shift;
        logic go_ins_wr;
        logic last_shift;
        logic is_insert;
        logic out_free;
    } iirl_sts_t;

endpackage

// ===== src/iirl_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module iirl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/iirl_ctrl.sv =====
// controller state machine for the indexed insert/remove list
// depends on iirl_pkg and the assertion macro header
`include "indexed_insert_remove_list_macros.svh"

module iirl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  iirl_pkg::iirl_sts_t sts,
    output iirl_pkg::iirl_cmd_t cmd
);

    import iirl_pkg::*;

    iirl_state_t state_reg;
    iirl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (sts.go_read)
                begin
                    state_next = ST_READ;
                end
                else if (sts.go_shift)
                begin
                    state_next = ST_SHIFT;
                end
                else if (sts.go_ins_wr)
                begin
                    state_next = ST_INS_WR;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_SHIFT:
            begin
                if (sts.last_shift)
                begin
                    state_next = sts.is_insert ? ST_INS_WR : ST_DONE;
                end
            end
            ST_INS_WR:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            ST_READ:
            begin
                cmd.capture = 1'b1;
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
            end
            ST_INS_WR:
            begin
                cmd.ins_write = 1'b1;
            end
            ST_DONE:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `IIRL_ASSERT_NEXT(a_shift_entry, state_reg != ST_SETUP && state_reg != ST_SHIFT, state_reg != ST_SHIFT, "shift entered from wrong state")
    `IIRL_ASSERT_NEXT(a_inswr_entry, state_reg != ST_SETUP && state_reg != ST_SHIFT, state_reg != ST_INS_WR, "insert write entered from wrong state")
    `IIRL_ASSERT_NEXT(a_setup_after_load, cmd.load, state_reg == ST_SETUP, "accepted transaction not set up")

endmodule

// ===== src/iirl_datapath.sv =====
// datapath for the indexed insert/remove list: request, index clamp, shift
// pointer, length count and result registers around the entry ram
// depends on iirl_pkg, iirl_ram and the assertion macro header
`include "indexed_insert_remove_list_macros.svh"

module iirl_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  iirl_pkg::iirl_cmd_t cmd,
    output iirl_pkg::iirl_sts_t sts,
    input  logic [1:0]         action,
    input  logic signed [7:0]  index,
    input  logic signed [31:0] item_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               ok,
    output logic signed [31:0] read_value,
    output logic [6:0]         count,
    output logic               empty_res
);

    import iirl_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 7) ? CW : 7;

    logic [1:0]        act_reg;
    logic [7:0]        idx_reg;
    logic [31:0]       val_reg;
    logic              ok_reg;
    logic [AW-1:0]     pos_reg;
    logic [AW-1:0]     ptr_reg;
    logic [31:0]       rd_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              out_valid_reg;
    logic              res_ok_reg;
    logic [31:0]       res_value_reg;
    logic [6:0]        res_count_reg;
    logic              res_empty_reg;

    logic              idx_neg;
    logic [XW-1:0]     idx_ext;
    logic [XW-1:0]     cnt_ext;
    logic [AW-1:0]     last_idx;
    logic [AW-1:0]     ins_pos;
    logic [AW-1:0]     rem_pos;
    logic              read_ok;
    logic              ins_ok;
    logic              rem_ok;
    logic              ins_shift;
    logic              rem_shift;
    logic              is_insert;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [31:0]       ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [31:0]       ram_rdata;

    iirl_ram #(
        .WIDTH(32),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // index decode and clamping against the current length
    always_comb
    begin
        idx_neg   = idx_reg[7];
        idx_ext   = XW'(idx_reg[6:0]);
        cnt_ext   = XW'(count_reg);
        last_idx  = AW'(count_reg - CW'(1));
        is_insert = (act_reg == ACT_INSERT);

        if (idx_neg)
        begin
            ins_pos = '0;
        end
        else if (idx_ext > cnt_ext)
        begin
            ins_pos = AW'(count_reg);
        end
        else
        begin
            ins_pos = AW'(idx_ext);
        end

        if (idx_neg)
        begin
            rem_pos = '0;
        end
        else if (idx_ext >= cnt_ext)
        begin
            rem_pos = last_idx;
        end
        else
        begin
            rem_pos = AW'(idx_ext);
        end

        read_ok   = (act_reg == ACT_READ) && !idx_neg && (idx_ext < cnt_ext);
        ins_ok    = is_insert && (count_reg != CW'(CAPACITY));
        rem_ok    = (act_reg == ACT_REMOVE) && (count_reg != '0);
        ins_shift = (ins_pos != AW'(count_reg));
        rem_shift = (rem_pos != last_idx);
    end

    always_comb
    begin
        sts.go_read    = read_ok;
        sts.go_shift   = (ins_ok && ins_shift) || (rem_ok && rem_shift);
        sts.go_ins_wr  = ins_ok && !ins_shift;
        sts.is_insert  = is_insert;
        sts.last_shift = is_insert ? (ptr_reg == pos_reg) : (ptr_reg == last_idx);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // ram addressing: one entry moved per cycle while shifting
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = ram_rdata;
        ram_raddr = ptr_reg;
        if (cmd.setup)
        begin
            case (act_reg)
                ACT_READ:   ram_raddr = AW'(idx_ext);
                ACT_INSERT: ram_raddr = last_idx;
                default:    ram_raddr = rem_pos + AW'(1);
            endcase
        end
        else if (cmd.shift)
        begin
            ram_we    = 1'b1;
            ram_waddr = is_insert ? (ptr_reg + AW'(1)) : (ptr_reg - AW'(1));
            ram_raddr = is_insert ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
        end
        else if (cmd.ins_write)
        begin
            ram_we    = 1'b1;
            ram_waddr = pos_reg;
            ram_wdata = val_reg;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ok_reg && (act_reg == ACT_INSERT))
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ok_reg && (act_reg == ACT_REMOVE))
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            idx_reg <= index;
            val_reg <= item_value;
        end
        if (cmd.setup)
        begin
            ok_reg  <= read_ok || ins_ok || rem_ok;
            pos_reg <= is_insert ? ins_pos : rem_pos;
            ptr_reg <= ram_raddr;
        end
        if (cmd.shift)
        begin
            ptr_reg <= ram_raddr;
        end
        if (cmd.capture)
        begin
            rd_reg <= ram_rdata;
        end
        if (cmd.finish)
        begin
            res_ok_reg    <= ok_reg;
            res_value_reg <= (ok_reg && (act_reg == ACT_READ)) ? rd_reg : '0;
            res_count_reg <= 7'(count_next);
            res_empty_reg <= (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                count_reg <= count_next;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign ok         = res_ok_reg;
    assign read_value = res_value_reg;
    assign count      = res_count_reg;
    assign empty_res  = res_empty_reg;

    `IIRL_ASSERT(a_count_max, count_reg <= CW'(CAPACITY), "length beyond capacity")
    `IIRL_ASSERT_NEXT(a_count_hold, !cmd.finish, $stable(count_reg), "length changed outside completion")
    `IIRL_ASSERT(a_read_empty, !(cmd.finish && ok_reg && act_reg == ACT_READ && count_reg == '0), "read succeeded on empty list")

endmodule

// ===== src/indexed_insert_remove_list.sv =====
// Indexed insert/remove list: an ordered list of signed 32-bit words in a
// CAPACITY-entry ram plus a length count. Each transaction reads, inserts or
// removes at an index and yields one result with ok, the word read, the new
// length and an empty flag. One transaction is worked at a time: a setup
// state, then as needed a read capture, a shift of the entries behind the
// position and/or the insert write, and a completion state. The shift moves
// one entry per cycle through the ram's single write port. A result waits in
// an output register, so the next transaction is accepted before it is taken.
// Depends on iirl_pkg, iirl_ctrl, iirl_datapath and iirl_ram.
module indexed_insert_remove_list #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic signed [7:0]  index,
    input  logic signed [31:0] item_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               ok,
    output logic signed [31:0] read_value,
    output logic [6:0]         count,
    output logic               empty_res
);

    import iirl_pkg::*;

    iirl_cmd_t cmd;
    iirl_sts_t sts;

    iirl_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    iirl_datapath #(
        .CAPACITY(CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .action    (action),
        .index     (index),
        .item_value(item_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ok        (ok),
        .read_value(read_value),
        .count     (count),
        .empty_res (empty_res)
    );

endmodule

// ===== tb/sv/tb_indexed_insert_remove_list.sv =====
// self-checking testbench for indexed_insert_remove_list: directed table, then random traffic
// checked against an in-bench list model; random idling on both sides, one long output hold-off
// depends on iirl_pkg and the indexed_insert_remove_list rtl
module tb_indexed_insert_remove_list;
    import iirl_pkg::*;

    localparam int CAPACITY = 64;
    localparam int RANDOM_ITEMS = 1500;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_AFTER = 200;
    localparam int HOLD_CYCLES = 400;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef enum int {
        FILL_MODE,
        DRAIN_MODE,
        MIXED_MODE
    } list_mode_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] rd;
        logic [6:0]  cnt;
        logic        empty;
    } list_result_t;

    typedef struct packed {
        logic [1:0]         act;
        logic signed [7:0]  idx;
        logic [31:0]        val;
        bit                 typed;
        list_result_t       want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         action;
    logic signed [7:0]  index;
    logic signed [31:0] item_value;
    logic               out_valid;
    logic               out_ready;
    logic               ok;
    logic signed [31:0] read_value;
    logic [6:0]         count;
    logic               empty_res;

    logic [31:0]  list_words [CAPACITY];
    int           list_len;
    list_result_t pending_results [$];
    int           error_count;
    int           cycle_count;

    // typed rows are read straight off the list behaviour; the rest use the model
    stim_row_t directed_rows [25] = '{
        '{ACT_READ,    8'sd0,    32'h0,        1'b1, '{1'b0, 32'h0,        7'd0, 1'b1}},
        '{ACT_REMOVE,  8'sd0,    32'h0,        1'b1, '{1'b0, 32'h0,        7'd0, 1'b1}},
        '{ACT_REMOVE,  -8'sd128, 32'h0,        1'b1, '{1'b0, 32'h0,        7'd0, 1'b1}},
        '{ACT_UNUSED,  8'sd5,    32'h1234_5678, 1'b1, '{1'b0, 32'h0,       7'd0, 1'b1}},
        '{ACT_INSERT,  8'sd0,    32'h7FFF_FFFF, 1'b1, '{1'b1, 32'h0,       7'd1, 1'b0}},
        '{ACT_INSERT,  -8'sd128, 32'h8000_0000, 1'b1, '{1'b1, 32'h0,       7'd2, 1'b0}},
        '{ACT_INSERT,  8'sd127,  32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0,       7'd3, 1'b0}},
        '{ACT_READ,    8'sd0,    32'h0,        1'b1, '{1'b1, 32'h8000_0000, 7'd3, 1'b0}},
        '{ACT_READ,    8'sd2,    32'h0,        1'b1, '{1'b1, 32'hFFFF_FFFF, 7'd3, 1'b0}},
        '{ACT_READ,    8'sd3,    32'h0,        1'b1, '{1'b0, 32'h0,        7'd3, 1'b0}},
        '{ACT_READ,    -8'sd1,   32'h0,        1'b1, '{1'b0, 32'h0,        7'd3, 1'b0}},
        '{ACT_READ,    8'sd127,  32'h0,        1'b1, '{1'b0, 32'h0,        7'd3, 1'b0}},
        '{ACT_READ,    -8'sd128, 32'h0,        1'b1, '{1'b0, 32'h0,        7'd3, 1'b0}},
        '{ACT_READ,    8'sd1,    32'h0,        1'b1, '{1'b1, 32'h7FFF_FFFF, 7'd3, 1'b0}},
        '{ACT_INSERT,  8'sd1,    32'h5A5A_5A5A, 1'b0, '0},
        '{ACT_INSERT,  8'sd3,    32'hA5A5_A5A5, 1'b0, '0},
        '{ACT_REMOVE,  8'sd127,  32'h0,        1'b0, '0},
        '{ACT_REMOVE,  -8'sd1,   32'hFFFF_FFFF, 1'b0, '0},
        '{ACT_REMOVE,  8'sd1,    32'h0,        1'b0, '0},
        '{ACT_READ,    8'sd0,    32'h0,        1'b0, '0},
        '{ACT_READ,    8'sd1,    32'h0,        1'b0, '0},
        '{ACT_UNUSED,  8'sd0,    32'hDEAD_BEEF, 1'b0, '0},
        '{ACT_REMOVE,  8'sd0,    32'h0,        1'b0, '0},
        '{ACT_REMOVE,  8'sd127,  32'h0,        1'b1, '{1'b1, 32'h0,        7'd0, 1'b1}},
        '{ACT_READ,    8'sd0,    32'h0,        1'b1, '{1'b0, 32'h0,        7'd0, 1'b1}}
    };

    indexed_insert_remove_list #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .index(index),
        .item_value(item_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .ok(ok),
        .read_value(read_value),
        .count(count),
        .empty_res(empty_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic list_result_t apply_list_op(input logic [1:0] act,
                                                   input logic signed [7:0] idx,
                                                   input logic [31:0] val);
        list_result_t res;
        int req;
        int pos;
        res = '0;
        req = idx;
        case (act)
            ACT_READ:
            begin
                if (req >= 0 && req < list_len)
                begin
                    res.rd = list_words[req];
                    res.ok = 1'b1;
                end
            end
            ACT_INSERT:
            begin
                if (list_len < CAPACITY)
                begin
                    pos = (req < 0) ? 0 : ((req > list_len) ? list_len : req);
                    for (int i = list_len; i > pos; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[pos] = val;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            ACT_REMOVE:
            begin
                if (list_len > 0)
                begin
                    pos = (req < 0) ? 0 : ((req >= list_len) ? list_len - 1 : req);
                    for (int i = pos; i + 1 < list_len; i++)
                        list_words[i] = list_words[i + 1];
                    list_words[list_len - 1] = '0;
                    list_len--;
                    res.ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.cnt = 7'(list_len);
        res.empty = (list_len == 0);
        return res;
    endfunction

    function automatic logic signed [7:0] pick_index();
        case ($urandom_range(0, 9))
            0: return 8'(-$urandom_range(1, 128));
            1: return 8'sd127;
            2: return -8'sd128;
            3: return 8'(list_len);
            4: return 8'(list_len - 1);
            5: return 8'sd0;
            6: return 8'($urandom_range(0, 127));
            default: return 8'($urandom_range(0, list_len));
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 19))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // called at a clock edge; returns at the edge where the transaction is accepted
    task automatic send_request(input logic [1:0] act, input logic signed [7:0] idx,
                                input logic [31:0] val, input bit typed,
                                input list_result_t want);
        int gap;
        list_result_t predicted;
        gap = $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        index      <= idx;
        item_value <= val;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = apply_list_op(act, idx, val);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic run_random_phase(input int target);
        int sent;
        int round;
        int round_len;
        int pick;
        list_mode_t mode;
        logic [1:0] act;
        sent = 0;
        round = 0;
        while (sent < target)
        begin
            if (round == 0)
            begin
                mode = FILL_MODE;
                round_len = CAPACITY + 6;
            end
            else if (round == 1)
            begin
                mode = DRAIN_MODE;
                round_len = CAPACITY + 6;
            end
            else
            begin
                mode = list_mode_t'($urandom_range(0, 2));
                round_len = $urandom_range(30, 120);
            end
            repeat (round_len)
            begin
                pick = $urandom_range(0, 99);
                if (pick == 0)
                    act = ACT_UNUSED;
                else if (round < 2)
                    act = (mode == FILL_MODE) ? ACT_INSERT : ACT_REMOVE;
                else
                begin
                    case (mode)
                        FILL_MODE:
                            act = (pick < 70) ? ACT_INSERT : ((pick < 85) ? ACT_READ : ACT_REMOVE);
                        DRAIN_MODE:
                            act = (pick < 70) ? ACT_REMOVE : ((pick < 85) ? ACT_READ : ACT_INSERT);
                        default:
                            act = (pick < 35) ? ACT_INSERT : ((pick < 70) ? ACT_REMOVE : ACT_READ);
                    endcase
                end
                send_request(act, pick_index(), pick_word(), 1'b0, '0);
                sent++;
            end
            round++;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no transaction pending, expected none actual %h",
                         $time, {ok, read_value, count, empty_res});
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("ok", 32'(want.ok), 32'(ok));
                check_field("read_value", want.rd, read_value);
                check_field("count", 32'(want.cnt), 32'(count));
                check_field("empty_res", 32'(want.empty), 32'(empty_res));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random gaps, plus one long hold-off so the block fills and stalls
    initial
    begin : result_sink
        int gap;
        int taken;
        bit held;
        taken = 0;
        held = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = $urandom_range(0, 4);
            if (!held && taken == HOLD_AFTER)
            begin
                gap = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            taken++;
        end
    end

    initial
    begin : request_source
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_READ;
        index = '0;
        item_value = '0;
        error_count = 0;
        cycle_count = 0;
        list_len = 0;
        foreach (list_words[i])
            list_words[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[r])
            send_request(directed_rows[r].act, directed_rows[r].idx, directed_rows[r].val,
                         directed_rows[r].typed, directed_rows[r].want);
        run_random_phase(RANDOM_ITEMS);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
